[rtl/rotation_invariant_lbp_stream_unit_defines.svh]
// Assertion macros shared by the LBP stream unit RTL.
`ifndef ROTATION_INVARIANT_LBP_STREAM_UNIT_DEFINES_SVH
`define ROTATION_INVARIANT_LBP_STREAM_UNIT_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define RILBP_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("rilbp: invariant violated");

// Antecedent at one edge implies consequent at the next edge.
`define RILBP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rilbp: sequence violated");

// Antecedent implies consequent at the same edge.
`define RILBP_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rilbp: implication violated");

`endif

[rtl/rilbp_pkg.sv]
// Shared types and constants for the rotation-invariant LBP stream unit.
package rilbp_pkg;

	typedef logic [7:0] pix_t;

	// 3x3 neighbourhood around the centre pixel
	typedef struct packed {
		pix_t tl;
		pix_t t;
		pix_t tr;
		pix_t r;
		pix_t br;
		pix_t b;
		pix_t bl;
		pix_t l;
		pix_t c;
	} window_t;

	// configuration register indexes
	typedef enum logic [0:0] {
		CFG_IMAGE_WIDTH  = 1'b0,
		CFG_IMAGE_HEIGHT = 1'b1
	} cfg_idx_t;

	localparam logic [11:0] WIDTH_RESET  = 12'd640;
	localparam logic [15:0] HEIGHT_RESET = 16'd480;
	localparam logic [15:0] HEIGHT_MIN   = 16'd3;

endpackage

[rtl/rilbp_pattern.sv]
// Neighbour comparison and rotation-minimum code for one 3x3 window.
module rilbp_pattern
	import rilbp_pkg::*;
(
	input  window_t win,
	output pix_t    code
);

	pix_t        base;
	pix_t        rot   [8];
	pix_t        best;
	logic [15:0] dbl;

	// bit per neighbour, top-left at bit 7 then clockwise
	always_comb begin
		base[7] = win.tl > win.c;
		base[6] = win.t  > win.c;
		base[5] = win.tr > win.c;
		base[4] = win.r  > win.c;
		base[3] = win.br > win.c;
		base[2] = win.b  > win.c;
		base[1] = win.bl > win.c;
		base[0] = win.l  > win.c;
	end

	// eight circular left rotations
	always_comb begin
		dbl = 16'h0;
		for (int r = 0; r < 8; r++) begin
			dbl    = {base, base} << r;
			rot[r] = dbl[15:8];
		end
	end

	// smallest rotation
	always_comb begin
		best = 8'hff;
		for (int r = 0; r < 8; r++) begin
			if (rot[r] < best) begin
				best = rot[r];
			end
		end
	end

	assign code = best;

endmodule

[rtl/rotation_invariant_lbp_stream_unit.sv]
// Top level of the rotation-invariant 3x3 LBP stream unit.
// Usage:
//  Pixel words enter on pixel_valid/pixel_ready in raster order; frame_start
//  marks the first pixel of a frame. Code words leave on lbp_valid/lbp_ready,
//  one per interior pixel (row >= 2, column >= 2); border pixels give none.
//  frame_last flags the code of the last interior pixel of the frame.
//  image_width and image_height are set through cfg_write/cfg_index/cfg_data
//  while the unit is idle; they are clamped to [3, MAX_WIDTH] and [3, 65535].
//  Throughput: one pixel per cycle unless a code stall holds the input. Both
//  line stores share one 16-bit wide memory that is read when a pixel is
//  accepted and written when that pixel leaves stage 1; a read that hits the
//  pending write is forwarded. A code is computed from stage 1 and registered
//  in the output register, which drives lbp_valid, lbp_code and frame_last.
//  When the receiver stalls, the code waits in the output register; pixels
//  that give no code still pass, and the next pixel that gives a code waits
//  in stage 1 and holds off further pixels until the code is taken.
//  Reset clears counters, window and handshake state and loads width 640 and
//  height 480; the line memory is not cleared and needs no clearing pass.
`include "rotation_invariant_lbp_stream_unit_defines.svh"

module rotation_invariant_lbp_stream_unit
	import rilbp_pkg::*;
#(
	parameter int MAX_WIDTH = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_write,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// pixel channel
	input  logic        pixel_valid,
	output logic        pixel_ready,
	input  logic [7:0]  pixel,
	input  logic        frame_start,
	// code channel
	output logic        lbp_valid,
	input  logic        lbp_ready,
	output logic [7:0]  lbp_code,
	output logic        frame_last
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);

	// configuration registers
	logic [11:0] image_width_q;
	logic [15:0] image_height_q;

	// counters
	logic [AW-1:0] col_q;
	logic [15:0]   row_q;

	// line memory: upper line in [15:8], middle line in [7:0]
	logic [15:0] line_mem [MAX_WIDTH];
	logic [15:0] rd_q;
	logic        fwd_q;
	logic [15:0] fwd_data_q;

	// stage 1
	logic          valid_s1;
	logic          res_s1;
	logic          last_s1;
	pix_t          pix_s1;
	logic [AW-1:0] idx_s1;

	// window columns: oldest column w0..w2, newer column w3..w5
	pix_t w0_q, w1_q, w2_q, w3_q, w4_q, w5_q;

	// output register
	logic lbp_valid_q;
	pix_t lbp_code_q;
	logic frame_last_q;

	logic          pix_fire;
	logic          go_s1;
	logic [31:0]   wide_w;
	logic [31:0]   eff_w;
	logic [WW-1:0] w_last;
	logic [15:0]   eff_h;
	logic [15:0]   h_last;
	logic [AW-1:0] col_cur;
	logic [15:0]   row_cur;
	logic          col_end;
	logic          row_end;
	pix_t          up_s1;
	pix_t          mid_s1;
	window_t       win;
	pix_t          code_s1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= WIDTH_RESET;
			image_height_q <= HEIGHT_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data[11:0];
				CFG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamped frame geometry
	always_comb begin
		wide_w = 32'(image_width_q);
		if (wide_w < 32'd3) begin
			eff_w = 32'd3;
		end else if (wide_w > 32'(MAX_WIDTH)) begin
			eff_w = 32'(MAX_WIDTH);
		end else begin
			eff_w = wide_w;
		end
		w_last = WW'(eff_w - 32'd1);
		eff_h  = (image_height_q < HEIGHT_MIN) ? HEIGHT_MIN : image_height_q;
		h_last = eff_h - 16'd1;
	end

	// handshakes
	assign go_s1       = valid_s1 && (!res_s1 || !lbp_valid_q || lbp_ready);
	assign pixel_ready = !valid_s1 || go_s1;
	assign pix_fire    = pixel_valid && pixel_ready;

	// position of the incoming pixel
	assign col_cur = frame_start ? '0 : col_q;
	assign row_cur = frame_start ? '0 : row_q;
	assign col_end = WW'(col_cur) >= w_last;
	assign row_end = row_cur >= h_last;

	// raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (pix_fire) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? 16'd0 : row_cur + 16'd1;
			end else begin
				col_q <= col_cur + AW'(1);
				row_q <= row_cur;
			end
		end
	end

	// line memory read, with forwarding of the write that lands on this edge
	always_ff @(posedge clk) begin
		if (pix_fire) begin
			rd_q       <= line_mem[col_cur];
			fwd_data_q <= {mid_s1, pix_s1};
		end
		if (go_s1) begin
			line_mem[idx_s1] <= {mid_s1, pix_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (pix_fire) begin
			fwd_q <= go_s1 && (idx_s1 == col_cur);
		end
	end

	assign up_s1  = fwd_q ? fwd_data_q[15:8] : rd_q[15:8];
	assign mid_s1 = fwd_q ? fwd_data_q[7:0]  : rd_q[7:0];

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			res_s1   <= 1'b0;
			last_s1  <= 1'b0;
		end else if (pix_fire) begin
			valid_s1 <= 1'b1;
			res_s1   <= (row_cur >= 16'd2) && (col_cur >= AW'(2));
			last_s1  <= row_end && col_end;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
			res_s1   <= 1'b0;
			last_s1  <= 1'b0;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (pix_fire) begin
			pix_s1 <= pixel;
			idx_s1 <= col_cur;
		end
	end

	// window shift as the item leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w0_q <= '0;
			w1_q <= '0;
			w2_q <= '0;
			w3_q <= '0;
			w4_q <= '0;
			w5_q <= '0;
		end else if (go_s1) begin
			w0_q <= w3_q;
			w1_q <= w4_q;
			w2_q <= w5_q;
			w3_q <= up_s1;
			w4_q <= mid_s1;
			w5_q <= pix_s1;
		end
	end

	// neighbourhood of the centre pixel
	always_comb begin
		win.tl = w0_q;
		win.t  = w3_q;
		win.tr = up_s1;
		win.r  = mid_s1;
		win.br = pix_s1;
		win.b  = w5_q;
		win.bl = w2_q;
		win.l  = w1_q;
		win.c  = w4_q;
	end

	rilbp_pattern u_pattern (
		.win  (win),
		.code (code_s1)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lbp_valid_q <= 1'b0;
		end else if (go_s1 && res_s1) begin
			lbp_valid_q <= 1'b1;
		end else if (lbp_ready) begin
			lbp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && res_s1) begin
			lbp_code_q   <= code_s1;
			frame_last_q <= last_s1;
		end
	end

	assign lbp_valid  = lbp_valid_q;
	assign lbp_code   = lbp_code_q;
	assign frame_last = frame_last_q;

	// checks
	`RILBP_ASSERT_ALWAYS(a_col_in_range, 32'(col_q) < 32'(MAX_WIDTH))
	`RILBP_ASSERT_SAME(a_stall_blocks_input, valid_s1 && res_s1 && lbp_valid_q && !lbp_ready, !pixel_ready)
	`RILBP_ASSERT_SAME(a_last_has_code, valid_s1 && last_s1, res_s1)
	`RILBP_ASSERT_NEXT(a_forward_on_hit, pix_fire && go_s1 && (idx_s1 == col_cur), fwd_q)

endmodule
